@@ hdl/crcfr_pkg.sv @@
// shared types, constants and crc function for the reply frame checker
package crcfr_pkg;

  localparam int unsigned CRC_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PREFIX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN      = 2'd2;

  localparam logic [CRC_W-1:0]  POLY_RESET     = 16'h8408;
  localparam logic [BYTE_W-1:0] PREFIX_RESET   = 8'hFC;
  localparam logic [BYTE_W-1:0] MIN_LEN_RESET  = 8'd5;
  localparam logic [BYTE_W-1:0] STRUCT_MIN_LEN = 8'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PREFIX = 3'd1,
    ST_BAD_LENGTH = 3'd2,
    ST_BAD_CRC    = 3'd3,
    ST_TIMEOUT    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CRC_W-1:0]  crc_polynomial;
    logic [BYTE_W-1:0] frame_prefix;
    logic [BYTE_W-1:0] min_frame_length;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    status_t           status;
  } result_t;

  // reflected crc update over one byte, lsb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [CRC_W-1:0] poly,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] value;
    logic [CRC_W-1:0]  acc;
    value = crc[BYTE_W-1:0] ^ b;
    acc   = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (acc[0] ^ value[k]) begin
        acc = (acc >> 1) ^ poly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc ^ {{(CRC_W-BYTE_W){1'b0}}, crc[CRC_W-1:BYTE_W]};
  endfunction

endpackage

@@ hdl/crcfr_if.sv @@
// channel interfaces: received bytes, results and configuration writes
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       abort;
  modport source (output valid, output rx_byte, output abort, input ready);
  modport sink (input valid, input rx_byte, input abort, output ready);
endinterface

interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  modport source (output valid, output kind, output payload_byte, output status, input ready);
  modport sink (input valid, input kind, input payload_byte, input status, output ready);
endinterface

interface crcfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/crc_framed_reply_checker.sv @@
// top level of the crc reply frame checker
// Checks length-prefixed reply frames (prefix, total length, payload, crc low,
// crc high) one received byte per transaction, passing payload bytes on and
// giving one status result per frame or per failing byte. Crc is reflected
// 16-bit with zero start value, updated by an unrolled 8-step network, one
// byte per cycle unless input stalls. Its result is registered in the output
// register, or in a skid entry behind it; this two-entry output buffer keeps
// input flowing while one result waits and stalls it only when both are full.
module crc_framed_reply_checker (
  input  logic        clk,
  input  logic        rst,
  crcfr_in_if.sink    rx,
  crcfr_out_if.source res,
  crcfr_cfg_if.sink   cfg
);
  import crcfr_pkg::*;

  cfg_t    cfg_q;
  logic    push;
  logic    push_ready;
  result_t push_data;

  crcfr_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  crcfr_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .cfg_q      (cfg_q),
    .rx         (rx),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  crcfr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .res        (res)
  );

endmodule

@@ hdl/crcfr_cfg_regs.sv @@
// configuration registers written through the configuration channel
module crcfr_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  crcfr_cfg_if.sink        cfg,
  output crcfr_pkg::cfg_t  cfg_q
);
  import crcfr_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid & cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.crc_polynomial   <= POLY_RESET;
      cfg_q.frame_prefix     <= PREFIX_RESET;
      cfg_q.min_frame_length <= MIN_LEN_RESET;
    end else if (wr) begin
      unique case (cfg.index)
        REG_CRC_POLY:     cfg_q.crc_polynomial   <= cfg.data;
        REG_FRAME_PREFIX: cfg_q.frame_prefix     <= cfg.data[BYTE_W-1:0];
        REG_MIN_LEN:      cfg_q.min_frame_length <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/crcfr_frame.sv @@
// frame tracking state, running crc and per-byte result generation
module crcfr_frame (
  input  logic               clk,
  input  logic               rst,
  input  crcfr_pkg::cfg_t    cfg_q,
  crcfr_in_if.sink           rx,
  input  logic               push_ready,
  output logic               push,
  output crcfr_pkg::result_t push_data
);
  import crcfr_pkg::*;

  logic [BYTE_W-1:0] byte_index, byte_index_next;
  logic [BYTE_W-1:0] frame_length, frame_length_next;
  logic [CRC_W-1:0]  running_crc, running_crc_next;
  logic [BYTE_W-1:0] crc_low_received, crc_low_received_next;

  logic              accept;
  logic [BYTE_W:0]   idx_p2;
  logic [BYTE_W:0]   len_ext;
  logic [CRC_W-1:0]  crc_upd;
  logic [CRC_W-1:0]  crc_got;

  assign rx.ready = push_ready;
  assign accept   = rx.valid & rx.ready;
  assign idx_p2   = {1'b0, byte_index} + (BYTE_W+1)'(2);
  assign len_ext  = {1'b0, frame_length};
  // running crc is zero while awaiting the prefix, so one update serves all crc-covered bytes
  assign crc_upd  = crc_byte(running_crc, cfg_q.crc_polynomial, rx.rx_byte);
  assign crc_got  = {rx.rx_byte, crc_low_received};

  always_comb begin
    byte_index_next       = byte_index;
    frame_length_next     = frame_length;
    running_crc_next      = running_crc;
    crc_low_received_next = crc_low_received;
    push                  = 1'b0;
    push_data.kind         = KIND_END;
    push_data.payload_byte = '0;
    push_data.status       = ST_OK;
    if (accept) begin
      priority if (rx.abort) begin
        byte_index_next       = '0;
        frame_length_next     = '0;
        running_crc_next      = '0;
        crc_low_received_next = '0;
        push                  = 1'b1;
        push_data.status      = ST_TIMEOUT;
      end else if (byte_index == '0) begin
        if (rx.rx_byte != cfg_q.frame_prefix) begin
          push             = 1'b1;
          push_data.status = ST_BAD_PREFIX;
        end else begin
          running_crc_next = crc_upd;
          byte_index_next  = BYTE_W'(1);
        end
      end else if (byte_index == BYTE_W'(1)) begin
        if (rx.rx_byte < cfg_q.min_frame_length || rx.rx_byte < STRUCT_MIN_LEN) begin
          byte_index_next       = '0;
          frame_length_next     = '0;
          running_crc_next      = '0;
          crc_low_received_next = '0;
          push                  = 1'b1;
          push_data.status      = ST_BAD_LENGTH;
        end else begin
          frame_length_next = rx.rx_byte;
          running_crc_next  = crc_upd;
          byte_index_next   = BYTE_W'(2);
        end
      end else if (idx_p2 < len_ext) begin
        running_crc_next       = crc_upd;
        byte_index_next        = byte_index + BYTE_W'(1);
        push                   = 1'b1;
        push_data.kind         = KIND_PAYLOAD;
        push_data.payload_byte = rx.rx_byte;
      end else if (idx_p2 == len_ext) begin
        crc_low_received_next = rx.rx_byte;
        byte_index_next       = byte_index + BYTE_W'(1);
      end else begin
        byte_index_next       = '0;
        frame_length_next     = '0;
        running_crc_next      = '0;
        crc_low_received_next = '0;
        push                  = 1'b1;
        push_data.status      = (crc_got == running_crc) ? ST_OK : ST_BAD_CRC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      frame_length     <= '0;
      running_crc      <= '0;
      crc_low_received <= '0;
    end else begin
      byte_index       <= byte_index_next;
      frame_length     <= frame_length_next;
      running_crc      <= running_crc_next;
      crc_low_received <= crc_low_received_next;
    end
  end

  a_idle_crc_clear: assert property (@(posedge clk) disable iff (rst)
    byte_index == '0 |-> running_crc == '0)
    else $error("running crc not clear while awaiting prefix");

  a_len_unset_early: assert property (@(posedge clk) disable iff (rst)
    (byte_index == '0 || byte_index == BYTE_W'(1)) |-> frame_length == '0)
    else $error("frame length set before length byte");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_index >= BYTE_W'(2) |-> (byte_index < frame_length && frame_length >= STRUCT_MIN_LEN))
    else $error("byte index outside frame");

endmodule

@@ hdl/crcfr_out_buf.sv @@
// two-entry output register with skid stage
module crcfr_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  crcfr_pkg::result_t push_data,
  output logic               push_ready,
  crcfr_out_if.source        res
);
  import crcfr_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign push_ready       = ~skid_valid;
  assign pop              = out_valid & res.ready;
  assign res.valid        = out_valid;
  assign res.kind         = out_data.kind;
  assign res.payload_byte = out_data.payload_byte;
  assign res.status       = out_data.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result pushed into full buffer");

endmodule

@@ verif/crc_framed_reply_checker_test.sv @@
// self-checking test of the crc reply frame checker: frame model, directed frames, random traffic
module crc_framed_reply_checker_test;
  import crcfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  crcfr_in_if  rx ();
  crcfr_out_if res ();
  crcfr_cfg_if cfg ();

  crc_framed_reply_checker dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  // register copies
  logic [15:0] poly_reg;
  logic [7:0]  prefix_reg;
  logic [7:0]  min_len_reg;

  // frame tracking state
  logic [7:0]  frame_pos;
  logic [7:0]  frame_len;
  logic [15:0] frame_crc;
  logic [7:0]  crc_lo_seen;

  result_t frame_results_due[$];
  result_t due;

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int failures;
  int cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] s;
    s = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      s = s[0] ? ((s >> 1) ^ poly) : (s >> 1);
    end
    return s;
  endfunction

  function automatic void frame_restart();
    frame_pos   = '0;
    frame_len   = '0;
    frame_crc   = '0;
    crc_lo_seen = '0;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] data,
                                      input status_t st);
    result_t r;
    r.kind         = kind;
    r.payload_byte = data;
    r.status       = st;
    frame_results_due.push_back(r);
  endfunction

  function automatic void track_frame_byte(input logic [7:0] b, input logic ab);
    if (ab) begin
      frame_restart();
      push_result(KIND_END, 8'h00, ST_TIMEOUT);
    end else if (frame_pos == 8'd0) begin
      if (b != prefix_reg) begin
        push_result(KIND_END, 8'h00, ST_BAD_PREFIX);
      end else begin
        frame_crc = crc_next(16'h0000, b, poly_reg);
        frame_pos = 8'd1;
      end
    end else if (frame_pos == 8'd1) begin
      if (b < min_len_reg || b < STRUCT_MIN_LEN) begin
        frame_restart();
        push_result(KIND_END, 8'h00, ST_BAD_LENGTH);
      end else begin
        frame_len = b;
        frame_crc = crc_next(frame_crc, b, poly_reg);
        frame_pos = 8'd2;
      end
    end else if (int'(frame_pos) + 2 < int'(frame_len)) begin
      frame_crc = crc_next(frame_crc, b, poly_reg);
      frame_pos = frame_pos + 8'd1;
      push_result(KIND_PAYLOAD, b, ST_OK);
    end else if (int'(frame_pos) + 2 == int'(frame_len)) begin
      crc_lo_seen = b;
      frame_pos   = frame_pos + 8'd1;
    end else begin
      if ({b, crc_lo_seen} == frame_crc) begin
        push_result(KIND_END, 8'h00, ST_OK);
      end else begin
        push_result(KIND_END, 8'h00, ST_BAD_CRC);
      end
      frame_restart();
    end
  endfunction

  task automatic send_rx_byte(input logic [7:0] b, input logic ab);
    while ($urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    rx.abort   <= ab;
    do @(posedge clk); while (!rx.ready);
    track_frame_byte(b, ab);
    bytes_sent++;
  endtask

  task automatic wait_for_quiet();
    rx.valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_CRC_POLY:     poly_reg    = data;
      REG_FRAME_PREFIX: prefix_reg  = data[7:0];
      REG_MIN_LEN:      min_len_reg = data[7:0];
      default: ;
    endcase
  endtask

  // fill < 0 gives random payload; abort_at >= 0 replaces that byte with an abort
  task automatic send_frame(input int len, input bit corrupt, input int abort_at,
                            input int fill);
    logic [15:0] c;
    logic [7:0]  b;
    int          eff_min;
    eff_min = (min_len_reg < STRUCT_MIN_LEN) ? int'(STRUCT_MIN_LEN) : int'(min_len_reg);
    c = 16'h0000;
    for (int i = 0; i < len; i++) begin
      if (i == abort_at) begin
        send_rx_byte(8'($urandom), 1'b1);
        return;
      end
      if (i == 0) begin
        b = prefix_reg;
      end else if (i == 1) begin
        b = 8'(len);
      end else if (i < len - 2) begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
      end else if (i == len - 2) begin
        if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
        b = c[7:0];
      end else begin
        b = c[15:8];
      end
      if (i < len - 2) c = crc_next(c, b, poly_reg);
      send_rx_byte(b, 1'b0);
      if (i == 1 && len < eff_min) return;
    end
  endtask

  function automatic int pick_frame_len();
    int eff_min;
    int len;
    eff_min = (min_len_reg < STRUCT_MIN_LEN) ? int'(STRUCT_MIN_LEN) : int'(min_len_reg);
    if ($urandom_range(99) < 3) begin
      len = $urandom_range(eff_min, 255);
    end else begin
      len = eff_min + $urandom_range(0, 10);
    end
    return (len > 255) ? 255 : len;
  endfunction

  task automatic return_to_prefix_wait();
    if (frame_pos != 8'd0) send_rx_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_frame_statuses();
    send_frame(5, 1'b0, -1, 8'hFF);
    send_rx_byte(8'h00, 1'b0);
    send_frame(4, 1'b0, -1, -1);
    send_rx_byte(8'h5A, 1'b1);
    send_frame(7, 1'b0, 3, -1);
    send_frame(5, 1'b1, -1, 8'h00);
    wait_for_quiet();
    write_reg(REG_MIN_LEN, 16'h0004);
    send_frame(4, 1'b0, -1, -1);
    wait_for_quiet();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_CRC_POLY, 16'hFFFF);
    write_reg(REG_FRAME_PREFIX, 16'h0000);
    write_reg(REG_MIN_LEN, 16'h00FF);
    send_frame(255, 1'b0, -1, -1);
    send_frame(254, 1'b0, -1, -1);
    wait_for_quiet();
    write_reg(REG_CRC_POLY, 16'h0000);
    write_reg(REG_FRAME_PREFIX, 16'hFFFF);
    write_reg(REG_MIN_LEN, 16'hFF04);
    send_frame(4, 1'b0, -1, -1);
    send_frame(3, 1'b0, -1, -1);
    send_frame(6, 1'b1, -1, -1);
    send_frame(6, 1'b0, -1, -1);
    wait_for_quiet();
  endtask

  task automatic random_phase(input int n, input int s_pct, input int r_pct);
    int          start;
    int          pick;
    int          len;
    logic [15:0] d;
    logic [7:0]  b;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    d = ($urandom_range(99) < 10) ? POLY_RESET : 16'($urandom);
    write_reg(REG_CRC_POLY, d);
    write_reg(REG_FRAME_PREFIX, 16'($urandom));
    d = 16'($urandom);
    d[7:0] = ($urandom_range(99) < 5) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(4, 9));
    write_reg(REG_MIN_LEN, d);
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        return_to_prefix_wait();
        send_frame(pick_frame_len(), $urandom_range(99) < 15, -1, -1);
      end else if (pick < 80) begin
        return_to_prefix_wait();
        len = pick_frame_len();
        send_frame(len, 1'b0, $urandom_range(0, len - 1), -1);
      end else if (pick < 88) begin
        return_to_prefix_wait();
        len = (min_len_reg < STRUCT_MIN_LEN) ? int'(STRUCT_MIN_LEN) : int'(min_len_reg);
        send_frame($urandom_range(0, len - 1), 1'b0, -1, -1);
      end else if (pick < 94) begin
        b = 8'($urandom);
        if (b == prefix_reg) b = ~b;
        send_rx_byte(b, 1'b0);
      end else begin
        send_rx_byte(8'($urandom), $urandom_range(99) < 20);
      end
    end
    wait_for_quiet();
  endtask

  task automatic test_random_frames();
    random_phase(100, 18, 76);
    random_phase(100, 76, 18);
    random_phase(100, 0, 0);
  endtask

  always @(posedge clk) begin
    res.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    if (!rst && res.valid && res.ready) begin
      if (frame_results_due.size() == 0) begin
        $display("%0t unexpected result: kind %0d byte %0h status %0d", $time,
                 res.kind, res.payload_byte, res.status);
        failures++;
      end else begin
        due = frame_results_due.pop_front();
        if (res.kind !== due.kind) begin
          $display("%0t kind: expected %0d actual %0d", $time, due.kind, res.kind);
          failures++;
        end
        if (res.payload_byte !== due.payload_byte) begin
          $display("%0t payload_byte: expected %0h actual %0h", $time,
                   due.payload_byte, res.payload_byte);
          failures++;
        end
        if (res.status !== due.status) begin
          $display("%0t status: expected %0d actual %0d", $time, due.status, res.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("crc_framed_reply_checker test failed");
      $finish;
    end
  end

  initial begin
    rst        <= 1'b1;
    rx.valid   <= 1'b0;
    rx.rx_byte <= 8'h00;
    rx.abort   <= 1'b0;
    cfg.valid  <= 1'b0;
    cfg.index  <= REG_CRC_POLY;
    cfg.data   <= 16'h0000;
    bytes_sent    = 0;
    send_idle_pct = 18;
    recv_idle_pct = 76;
    poly_reg      = POLY_RESET;
    prefix_reg    = PREFIX_RESET;
    min_len_reg   = MIN_LEN_RESET;
    frame_restart();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_frame_statuses();
    test_register_extremes();
    test_random_frames();
    repeat (20) @(posedge clk);
    if (failures == 0 && frame_results_due.size() == 0) begin
      $display("crc_framed_reply_checker test passed");
    end else begin
      $display("crc_framed_reply_checker test failed");
    end
    $finish;
  end

endmodule
